>>> sv/tach_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types and constants of the capture tachometer: word codes, state
// encoding, field widths and the reset value of the dividend register.
// ----------------------------------------------------------------------------
package tach_pkg;

    // default configuration of the averaging ring and the timer
    localparam int AVG_LOG2_DEF   = 2;
    localparam int TIMER_BITS_DEF = 16;

    // fixed field widths
    localparam int FIELD_W    = 16;
    localparam int DIVIDEND_W = 32;

    // saturation and stall limits
    localparam logic [FIELD_W-1:0] FIELD_MAX   = 16'hFFFF;
    localparam logic [1:0]         STALL_LIMIT = 2'd2;

    // reset value of the dividend register
    localparam logic [DIVIDEND_W-1:0] RPM_DIVIDEND_RESET = 32'd1600000;

    // input word codes
    typedef enum logic
    {
        CMD_CAPTURE  = 1'b0,
        CMD_OVERFLOW = 1'b1
    } tach_cmd_t;

    // sequencer states of the core
    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } tach_state_t;

endpackage
`default_nettype wire

>>> sv/tach_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tach_div
// Bit-serial restoring divider: one quotient bit per cycle, 32 quotient bits per
// division. The quotient is saturated to 16 bits on the fly with a sticky
// overflow flag, so only the low 16 quotient bits are kept.
// ----------------------------------------------------------------------------
module tach_div #(
    parameter int DIVISOR_W = tach_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [tach_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]            divisor,
    output logic                                 done,
    output logic [tach_pkg::FIELD_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(tach_pkg::DIVIDEND_W);

    logic                            busy_reg;
    logic                            done_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [tach_pkg::DIVIDEND_W-1:0] num_reg;
    logic [DIVISOR_W-1:0]            den_reg;
    logic [DIVISOR_W-1:0]            rem_reg;
    logic [tach_pkg::FIELD_W-1:0]    q_reg;
    logic                            ovf_reg;

    logic [DIVISOR_W:0]              trial;
    logic [DIVISOR_W:0]              diff;
    logic                            fits;

    // one trial subtraction per cycle
    always_comb
    begin
        trial = {rem_reg, num_reg[tach_pkg::DIVIDEND_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(tach_pkg::DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[tach_pkg::DIVIDEND_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            ovf_reg <= ovf_reg | q_reg[tach_pkg::FIELD_W-1];
            q_reg   <= {q_reg[tach_pkg::FIELD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = ovf_reg ? tach_pkg::FIELD_MAX : q_reg;

endmodule
`default_nettype wire

>>> sv/tachometer_rpm_from_capture_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tachometer_rpm_from_capture_core
// Turns timer capture and overflow words into a speed in RPM over a moving
// average of the last 2^AVG_LOG2 capture periods.
// ----------------------------------------------------------------------------
// Every input word (capture or overflow) yields one result word. A word whose
// result needs a division passes ST_UPDATE, ST_START, ST_DIVIDE, where the
// bit-serial divider resolves one of the 32 quotient bits per cycle, and
// ST_DONE; a word that gives rpm 0 (stalled, or zero average period) skips
// ST_DIVIDE. One word is in work at a time; the next word is accepted as soon
// as the previous result sits in the output register, even while that result
// still waits to be taken. The period ring is a memory of 2^AVG_LOG2 entries
// with one valid bit per entry, so it reads as zero after reset with no clearing
// pass. The user writes rpm_dividend (dividend_reg) through cfg_write_en and
// cfg_write_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module tachometer_rpm_from_capture_core #(
    parameter int AVG_LOG2   = tach_pkg::AVG_LOG2_DEF,
    parameter int TIMER_BITS = tach_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_write_en,
    input  wire logic [tach_pkg::DIVIDEND_W-1:0] cfg_write_data,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            command,
    input  wire logic [tach_pkg::FIELD_W-1:0]    capture_time,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [tach_pkg::FIELD_W-1:0]         rpm,
    output logic [tach_pkg::FIELD_W-1:0]         average_period,
    output logic                                 stalled
);

    localparam int RING_DEPTH = 1 << AVG_LOG2;
    localparam int RING_AW    = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
    localparam int TOTAL_W    = TIMER_BITS + AVG_LOG2;
    localparam int MEAN_EXT_W = (TIMER_BITS > tach_pkg::FIELD_W) ? TIMER_BITS
                                                                 : tach_pkg::FIELD_W;

    tach_pkg::tach_state_t state_reg, state_next;

    logic [tach_pkg::DIVIDEND_W-1:0] dividend_reg;
    logic                            cmd_reg;
    logic [TIMER_BITS-1:0]           now_reg;
    logic [TIMER_BITS-1:0]           prev_reg;
    logic [RING_AW-1:0]              pos_reg;
    logic [TOTAL_W-1:0]              total_reg;
    logic [TIMER_BITS-1:0]           mean_reg;
    logic [1:0]                      ovf_cnt_reg;
    logic [tach_pkg::FIELD_W-1:0]    rpm_res_reg;

    logic [TIMER_BITS-1:0]           ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]           ring_vld_reg;
    logic [TIMER_BITS-1:0]           ring_rd_reg;
    logic                            old_vld_reg;

    logic                            out_valid_reg;
    logic [tach_pkg::FIELD_W-1:0]    rpm_reg;
    logic [tach_pkg::FIELD_W-1:0]    avg_reg;
    logic                            stalled_reg;

    logic                            in_accept;
    logic                            out_load;
    logic                            div_start;
    logic                            div_done;
    logic [tach_pkg::FIELD_W-1:0]    div_q;
    logic                            is_stalled;
    logic                            rpm_zero;
    logic [TIMER_BITS-1:0]           old_period;
    logic [TIMER_BITS-1:0]           delta;
    logic [TOTAL_W-1:0]              total_next;
    logic [MEAN_EXT_W-1:0]           mean_ext;
    logic [tach_pkg::FIELD_W-1:0]    avg_sat;

    // ring arithmetic: wrapping period, running sum, mean
    always_comb
    begin
        old_period = old_vld_reg ? ring_rd_reg : '0;
        delta      = now_reg - prev_reg;
        total_next = total_reg - TOTAL_W'(old_period) + TOTAL_W'(delta);
        is_stalled = (ovf_cnt_reg == tach_pkg::STALL_LIMIT);
        rpm_zero   = is_stalled || (mean_reg == '0);
        mean_ext   = MEAN_EXT_W'(mean_reg);
        avg_sat    = (mean_ext > MEAN_EXT_W'(tach_pkg::FIELD_MAX)) ? tach_pkg::FIELD_MAX
                                                                   : mean_ext[tach_pkg::FIELD_W-1:0];
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tach_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencer next state and strobes
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        in_accept  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                in_accept = in_valid;
                if (in_valid)
                begin
                    state_next = tach_pkg::ST_UPDATE;
                end
            end
            tach_pkg::ST_UPDATE:
            begin
                state_next = tach_pkg::ST_START;
            end
            tach_pkg::ST_START:
            begin
                if (rpm_zero)
                begin
                    state_next = tach_pkg::ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = tach_pkg::ST_DIVIDE;
                end
            end
            tach_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = tach_pkg::ST_DONE;
                end
            end
            tach_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = tach_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tach_pkg::ST_IDLE;
            end
        endcase
    end

    // control state: config register, capture history, ring position, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dividend_reg <= tach_pkg::RPM_DIVIDEND_RESET;
            prev_reg     <= '0;
            pos_reg      <= '0;
            total_reg    <= '0;
            mean_reg     <= '0;
            ovf_cnt_reg  <= '0;
            ring_vld_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                dividend_reg <= cfg_write_data;
            end
            if (state_reg == tach_pkg::ST_UPDATE)
            begin
                if (cmd_reg == tach_pkg::CMD_CAPTURE)
                begin
                    prev_reg              <= now_reg;
                    total_reg             <= total_next;
                    mean_reg              <= total_next[TOTAL_W-1 -: TIMER_BITS];
                    ovf_cnt_reg           <= '0;
                    ring_vld_reg[pos_reg] <= 1'b1;
                    if (pos_reg == RING_AW'(RING_DEPTH - 1))
                    begin
                        pos_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                else if (ovf_cnt_reg != tach_pkg::STALL_LIMIT)
                begin
                    ovf_cnt_reg <= ovf_cnt_reg + 1'b1;
                end
            end
        end
    end

    // input word capture and ring read
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg     <= command;
            now_reg     <= TIMER_BITS'(capture_time);
            ring_rd_reg <= ring_mem[pos_reg];
            old_vld_reg <= ring_vld_reg[pos_reg];
        end
    end

    // ring write
    always_ff @(posedge clk)
    begin
        if (state_reg == tach_pkg::ST_UPDATE && cmd_reg == tach_pkg::CMD_CAPTURE)
        begin
            ring_mem[pos_reg] <= delta;
        end
    end

    // result speed: zero or divider output
    always_ff @(posedge clk)
    begin
        if (state_reg == tach_pkg::ST_START && rpm_zero)
        begin
            rpm_res_reg <= '0;
        end
        else if (state_reg == tach_pkg::ST_DIVIDE && div_done)
        begin
            rpm_res_reg <= div_q;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rpm_reg     <= rpm_res_reg;
            avg_reg     <= avg_sat;
            stalled_reg <= is_stalled;
        end
    end

    // bit-serial divider
    tach_div #(
        .DIVISOR_W (TIMER_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (mean_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid      = out_valid_reg;
    assign rpm            = rpm_reg;
    assign average_period = avg_reg;
    assign stalled        = stalled_reg;

endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: capture tachometer core bench
// Runs timer capture and overflow words through the core and checks every
// result word against an in-bench model of the ring average, the stall count
// and the saturating divide. Directed words cover reset, timestamp wrap,
// quotient saturation and stall recovery. Random capture trains follow, with
// overflow and timestamp noise, under three idling mixes and several dividends.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_LOG2    = tach_pkg::AVG_LOG2_DEF;
    localparam int RING_DEPTH  = 1 << AVG_LOG2;
    localparam int SUM_W       = tach_pkg::FIELD_W + AVG_LOG2;
    localparam int CYCLE_LIMIT = 400000;

    // one result word
    typedef struct packed
    {
        logic [tach_pkg::FIELD_W-1:0] rpm;
        logic [tach_pkg::FIELD_W-1:0] average_period;
        logic                         stalled;
    } speed_word_t;

    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            cfg_write_en   = 1'b0;
    logic [tach_pkg::DIVIDEND_W-1:0] cfg_write_data = '0;
    logic                            in_valid       = 1'b0;
    logic                            in_stall;
    logic                            command        = 1'b0;
    logic [tach_pkg::FIELD_W-1:0]    capture_time   = '0;
    logic                            out_valid;
    logic                            out_stall      = 1'b0;
    logic [tach_pkg::FIELD_W-1:0]    rpm;
    logic [tach_pkg::FIELD_W-1:0]    average_period;
    logic                            stalled;

    // model state of the speed calculation
    logic [tach_pkg::DIVIDEND_W-1:0] dividend    = tach_pkg::RPM_DIVIDEND_RESET;
    logic [tach_pkg::FIELD_W-1:0]    last_stamp  = '0;
    logic [tach_pkg::FIELD_W-1:0]    period_hist [RING_DEPTH] = '{default: '0};
    logic [AVG_LOG2-1:0]             hist_slot   = '0;
    logic [SUM_W-1:0]                hist_total  = '0;
    logic [tach_pkg::FIELD_W-1:0]    mean_period = '0;
    logic [1:0]                      ovf_count   = '0;

    speed_word_t                  expected_speeds[$];
    int unsigned                  fails             = 0;
    int unsigned                  cycles            = 0;
    int                           sender_idle_pct   = 0;
    int                           receiver_idle_pct = 0;
    logic [tach_pkg::FIELD_W-1:0] next_stamp        = '0;

    tachometer_rpm_from_capture_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .capture_time   (capture_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .rpm            (rpm),
        .average_period (average_period),
        .stalled        (stalled)
    );

    // clock
    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    // advance the model by one word and return the speed it should report
    function automatic speed_word_t predict_speed(input tach_pkg::tach_cmd_t cmd,
                                                  input logic [tach_pkg::FIELD_W-1:0] stamp);
        logic [tach_pkg::FIELD_W-1:0]    period;
        logic [tach_pkg::DIVIDEND_W-1:0] quotient;
        speed_word_t                     w;
        if (cmd == tach_pkg::CMD_CAPTURE)
        begin
            // wrapping period since the last capture replaces the oldest entry
            period     = stamp - last_stamp;
            ovf_count  = '0;
            last_stamp = stamp;
            hist_total = hist_total - period_hist[hist_slot] + period;
            period_hist[hist_slot] = period;
            mean_period = hist_total[SUM_W-1:AVG_LOG2];
            hist_slot   = hist_slot + 1'b1;
        end
        else if (ovf_count < tach_pkg::STALL_LIMIT)
        begin
            ovf_count = ovf_count + 1'b1;
        end
        w.stalled        = (ovf_count >= tach_pkg::STALL_LIMIT);
        w.average_period = mean_period;
        w.rpm            = '0;
        // no speed when stalled or the average period is zero
        if (!w.stalled && mean_period != '0)
        begin
            quotient = dividend / mean_period;
            w.rpm    = (quotient > tach_pkg::FIELD_MAX) ? tach_pkg::FIELD_MAX
                                                        : quotient[tach_pkg::FIELD_W-1:0];
        end
        return w;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        speed_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_speeds.size() == 0)
            begin
                $error("result word with nothing expected: rpm %0d avg %0d stalled %0d",
                       rpm, average_period, stalled);
                fails++;
            end
            else
            begin
                exp_w = expected_speeds.pop_front();
                if (rpm !== exp_w.rpm)
                begin
                    $error("rpm mismatch: expected %0d, actual %0d", exp_w.rpm, rpm);
                    fails++;
                end
                if (average_period !== exp_w.average_period)
                begin
                    $error("average_period mismatch: expected %0d, actual %0d",
                           exp_w.average_period, average_period);
                    fails++;
                end
                if (stalled !== exp_w.stalled)
                begin
                    $error("stalled mismatch: expected %0d, actual %0d",
                           exp_w.stalled, stalled);
                    fails++;
                end
            end
        end
    end

    // send one word, idling the sender cycle by cycle first; returns at acceptance
    task automatic send_word(input tach_pkg::tach_cmd_t cmd,
                             input logic [tach_pkg::FIELD_W-1:0] stamp);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        capture_time <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_speeds.push_back(predict_speed(cmd, stamp));
    endtask

    // hold off the sender until every result word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // write the dividend register while the core is idle
    task automatic load_dividend(input logic [tach_pkg::DIVIDEND_W-1:0] value);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        dividend = value;
    endtask

    // zero average right after reset, then stall from two overflows
    task automatic test_reset_state();
        send_word(tach_pkg::CMD_OVERFLOW, 16'h0000);
        send_word(tach_pkg::CMD_CAPTURE, 16'h0000);
        send_word(tach_pkg::CMD_OVERFLOW, 16'hFFFF);
        send_word(tach_pkg::CMD_OVERFLOW, 16'h0000);
    endtask

    // full-range timestamps and wrap across zero
    task automatic test_timestamp_wrap();
        send_word(tach_pkg::CMD_CAPTURE, 16'hFFFF);
        send_word(tach_pkg::CMD_CAPTURE, 16'h0000);
        send_word(tach_pkg::CMD_CAPTURE, 16'h8000);
        send_word(tach_pkg::CMD_CAPTURE, 16'h7FFF);
        next_stamp = 16'h7FFF;
    endtask

    // quotient saturation with the largest dividend, smallest dividend after
    task automatic test_quotient_limits();
        load_dividend(32'hFFFF_FFFF);
        repeat (4)
        begin
            next_stamp = next_stamp + 1'b1;
            send_word(tach_pkg::CMD_CAPTURE, next_stamp);
        end
        load_dividend(32'd1);
        repeat (3)
        begin
            next_stamp = next_stamp + 1'b1;
            send_word(tach_pkg::CMD_CAPTURE, next_stamp);
        end
        next_stamp = next_stamp + 16'd2;
        send_word(tach_pkg::CMD_CAPTURE, next_stamp);
        load_dividend(tach_pkg::RPM_DIVIDEND_RESET);
    endtask

    // overflow count saturates, a capture clears the stall
    task automatic test_stall_recovery();
        repeat (3) send_word(tach_pkg::CMD_OVERFLOW, 16'h5A5A);
        next_stamp = next_stamp + 16'd3000;
        send_word(tach_pkg::CMD_CAPTURE, next_stamp);
    endtask

    // capture trains with random periods, overflow and timestamp noise
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [tach_pkg::DIVIDEND_W-1:0] value,
                                       input int count);
        int          sent;
        int          train_left;
        int          r;
        int unsigned base_period;
        load_dividend(value);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        sent        = 0;
        train_left  = 0;
        base_period = 1;
        while (sent < count)
        begin
            if (train_left == 0)
            begin
                train_left = $urandom_range(24, 4);
                case ($urandom_range(2))
                    0:       base_period = $urandom_range(40, 1);
                    1:       base_period = $urandom_range(2000, 20);
                    default: base_period = $urandom_range(65535, 1000);
                endcase
            end
            train_left--;
            r = $urandom_range(99);
            if (r < 4)
            begin
                repeat (3)
                    send_word(tach_pkg::CMD_OVERFLOW,
                              tach_pkg::FIELD_W'($urandom_range(65535)));
                sent += 3;
            end
            else if (r < 12)
            begin
                send_word(tach_pkg::CMD_OVERFLOW, tach_pkg::FIELD_W'($urandom_range(65535)));
                sent++;
            end
            else if (r < 22)
            begin
                // stray timestamp; the train carries on from it
                next_stamp = tach_pkg::FIELD_W'($urandom_range(65535));
                send_word(tach_pkg::CMD_CAPTURE, next_stamp);
                sent++;
            end
            else
            begin
                next_stamp = tach_pkg::FIELD_W'(next_stamp + base_period
                                                + $urandom_range(base_period >> 3));
                send_word(tach_pkg::CMD_CAPTURE, next_stamp);
                sent++;
            end
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    // test sequence
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_timestamp_wrap();
        test_quotient_limits();
        test_stall_recovery();
        test_random_traffic(29, 74, $urandom_range(32'hFFFF_FFFF, 1), 134);
        test_random_traffic(74, 29, $urandom_range(100000, 1), 133);
        test_random_traffic(0, 0, tach_pkg::RPM_DIVIDEND_RESET, 133);
        drain_results();
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> tachometer_rpm_from_capture_core.f
sv/tach_pkg.sv
sv/tach_div.sv
sv/tachometer_rpm_from_capture_core.sv
bench/tb.sv
